FILE: hw/rtl/cddt_pkg.sv
// Package for the calibration due-date tracker.
// Holds the microcode word, status and action types, the program ROM and the month-length table.
// No dependencies.
package cddt_pkg;

  localparam int unsigned YearW  = 7;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned IntW   = 12;
  // Working day count: day plus interval, up to 31 + 4095.
  localparam int unsigned SumW   = 13;
  localparam int unsigned StepW  = 3;

  localparam logic [YearW-1:0]  YearMax  = 7'd127;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [MonthW-1:0] MonthJan = 4'd1;

  typedef logic [StepW-1:0] step_t;

  // Program step addresses.
  localparam step_t StepWait     = 3'd0;
  localparam step_t StepDispatch = 3'd1;
  localparam step_t StepWalk     = 3'd2;
  localparam step_t StepCheck    = 3'd3;
  localparam step_t StepStore    = 3'd4;
  localparam step_t StepEmit     = 3'd5;

  // Jump conditions.
  typedef enum logic [2:0] {
    CondNever,
    CondAlways,
    CondAccept,
    CondIsCheck,
    CondDayFits,
    CondOutFree
  } cond_e;

  typedef struct packed {
    logic  accept;   // open the input channel
    logic  walk;     // advance one month while the condition is false
    logic  compare;  // evaluate today against the stored date
    logic  store;    // commit the walked date
    logic  emit;     // load the result beat when the condition is true
    logic  hold;     // stay on this step while the condition is false
    cond_e cond;
    step_t target;   // jump target when the condition is true
  } ctrl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic in_beat;
    logic is_check;
    logic day_fits;
    logic out_free;
  } status_t;

  // Gated actions from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic walk;
    logic compare;
    logic store;
    logic emit;
  } action_t;

  function automatic ctrl_t program_rom(input step_t step);
    ctrl_t w;
    w = '{accept: 1'b0, walk: 1'b0, compare: 1'b0, store: 1'b0, emit: 1'b0,
          hold: 1'b0, cond: CondAlways, target: StepWait};
    case (step)
      StepWait: begin
        w.accept = 1'b1;
        w.hold   = 1'b1;
        w.cond   = CondAccept;
        w.target = StepDispatch;
      end
      StepDispatch: begin
        w.cond   = CondIsCheck;
        w.target = StepCheck;
      end
      StepWalk: begin
        w.walk   = 1'b1;
        w.hold   = 1'b1;
        w.cond   = CondDayFits;
        w.target = StepStore;
      end
      StepCheck: begin
        w.compare = 1'b1;
        w.cond    = CondAlways;
        w.target  = StepEmit;
      end
      StepStore: begin
        w.store  = 1'b1;
        w.cond   = CondNever;
        w.target = StepWait;
      end
      StepEmit: begin
        w.emit   = 1'b1;
        w.hold   = 1'b1;
        w.cond   = CondOutFree;
        w.target = StepWait;
      end
      default: begin
        w.cond   = CondAlways;
        w.target = StepWait;
      end
    endcase
    return w;
  endfunction

  // Every year divisible by four is a leap year; months outside 1..12 run 30 days.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic [YearW-1:0] year);
    logic [DayW-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default: len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

FILE: hw/rtl/cddt_seq.sv
// Microcode sequencer: step counter, program ROM and conditional jumps.
// Depends on cddt_pkg.
module cddt_seq
  import cddt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output logic    in_ready_o,
  output action_t action_o
);

  step_t step_q, step_d;
  ctrl_t ctrl;
  logic  cond_true;

  assign ctrl = program_rom(step_q);

  always_comb begin
    case (ctrl.cond)
      CondNever:   cond_true = 1'b0;
      CondAlways:  cond_true = 1'b1;
      CondAccept:  cond_true = status_i.in_beat;
      CondIsCheck: cond_true = status_i.is_check;
      CondDayFits: cond_true = status_i.day_fits;
      CondOutFree: cond_true = status_i.out_free;
      default:     cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      step_d = ctrl.target;
    end else if (ctrl.hold) begin
      step_d = step_q;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  assign in_ready_o       = ctrl.accept;
  assign action_o.load    = ctrl.accept & status_i.in_beat;
  assign action_o.walk    = ctrl.walk & ~cond_true;
  assign action_o.compare = ctrl.compare;
  assign action_o.store   = ctrl.store;
  assign action_o.emit    = ctrl.emit & cond_true;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepWait;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: hw/rtl/cddt_datapath.sv
// Datapath: working date, month walker, due-date store, comparator and result register.
// Depends on cddt_pkg.
module cddt_datapath
  import cddt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  action_t           action_i,
  input  logic [IntW-1:0]   interval_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              func_i,
  input  logic [YearW-1:0]  today_year_i,
  input  logic [MonthW-1:0] today_month_i,
  input  logic [DayW-1:0]   today_day_i,
  output status_t           status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              is_due_o,
  output logic [YearW-1:0]  due_year_o,
  output logic [MonthW-1:0] due_month_o,
  output logic [DayW-1:0]   due_day_o
);

  // Working item.
  logic              sched_q;
  logic [YearW-1:0]  year_q;
  logic [MonthW-1:0] month_q;
  logic [DayW-1:0]   today_day_q;
  logic [SumW-1:0]   sum_q;
  logic              flag_q;

  // Stored due date.
  logic [YearW-1:0]  due_year_q;
  logic [MonthW-1:0] due_month_q;
  logic [DayW-1:0]   due_day_q;

  // Result beat.
  logic              out_valid_q;
  logic              out_is_due_q;
  logic [YearW-1:0]  out_year_q;
  logic [MonthW-1:0] out_month_q;
  logic [DayW-1:0]   out_day_q;

  logic [DayW-1:0]   len;
  logic              last_month;
  logic              today_due;

  assign len        = month_len(month_q, year_q);
  assign last_month = (month_q >= MonthDec);

  always_comb begin
    if (year_q != due_year_q) begin
      today_due = (year_q > due_year_q);
    end else if (month_q != due_month_q) begin
      today_due = (month_q > due_month_q);
    end else begin
      today_due = (today_day_q >= due_day_q);
    end
  end

  assign status_o.in_beat  = in_valid_i & in_ready_i;
  assign status_o.is_check = ~sched_q;
  assign status_o.day_fits = (sum_q <= SumW'(len));
  assign status_o.out_free = ~out_valid_q | out_ready_i;

  // Working registers carry payload only.
  always_ff @(posedge clk_i) begin
    if (action_i.load) begin
      sched_q     <= func_i;
      year_q      <= today_year_i;
      month_q     <= today_month_i;
      today_day_q <= today_day_i;
      sum_q       <= SumW'(today_day_i) + SumW'(interval_i);
    end else if (action_i.walk) begin
      sum_q <= sum_q - SumW'(len);
      if (last_month) begin
        month_q <= MonthJan;
        if (year_q != YearMax) begin
          year_q <= year_q + YearW'(1);
        end
      end else begin
        month_q <= month_q + MonthW'(1);
      end
    end
    if (action_i.compare) begin
      flag_q <= today_due;
    end else if (action_i.store) begin
      flag_q <= 1'b0;
    end
    if (action_i.emit) begin
      out_is_due_q <= flag_q;
      out_year_q   <= due_year_q;
      out_month_q  <= due_month_q;
      out_day_q    <= due_day_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_year_q  <= '0;
      due_month_q <= '0;
      due_day_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (action_i.store) begin
        due_year_q  <= year_q;
        due_month_q <= month_q;
        due_day_q   <= sum_q[DayW-1:0];
      end
      if (action_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_due_o    = out_is_due_q;
  assign due_year_o  = out_year_q;
  assign due_month_o = out_month_q;
  assign due_day_o   = out_day_q;

endmodule

FILE: hw/rtl/calibration_due_date_tracker.sv
// Calibration due-date tracker: a check beat goes through dispatch, check and emit to its
// result beat; a schedule beat goes through dispatch, the month walk (up to about 135
// months at interval 4095), store and emit. The walk advances one month a cycle through the subtractor.
// One beat is in work at a time: a new beat is taken only once the last one has reached
// emit and loaded its result beat, and the next beat is taken while a result beat waits.
// Reset (async, active low) clears the stored due date, interval, step counter and valid.
module calibration_due_date_tracker
  import cddt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB-style configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Input beat
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [YearW-1:0]  today_year_i,
  input  logic [MonthW-1:0] today_month_i,
  input  logic [DayW-1:0]   today_day_i,
  // Result beat
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              is_due_o,
  output logic [YearW-1:0]  due_year_o,
  output logic [MonthW-1:0] due_month_o,
  output logic [DayW-1:0]   due_day_o
);

  localparam logic RegInterval = 1'b0;

  logic [IntW-1:0] interval_q;
  logic            cfg_wr;
  status_t         status;
  action_t         action;

  // Register file: a single interval register at byte address 0.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == RegInterval);
  assign prdata = (paddr[2] == RegInterval) ? {{(32 - IntW){1'b0}}, interval_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
    end else if (cfg_wr) begin
      interval_q <= pwdata[IntW-1:0];
    end
  end

  // Sequencer walks the program: wait, dispatch, then walk and store or check, then emit.
  cddt_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .action_o   (action)
  );

  // Datapath does the month walk, holds the due date and the result beat.
  cddt_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (action),
    .interval_i    (interval_q),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .func_i        (func_i),
    .today_year_i  (today_year_i),
    .today_month_i (today_month_i),
    .today_day_i   (today_day_i),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_due_o      (is_due_o),
    .due_year_o    (due_year_o),
    .due_month_o   (due_month_o),
    .due_day_o     (due_day_o)
  );

endmodule
